// ----- hdl/bmf_pkg.sv -----
// Shared types and constants of the box mean filter.
package bmf_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;
    localparam int RAD_W = 2;
    localparam int QUO_W = 8;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 11'd1024;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT  = 11'd1024;
    localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS = 2'd1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // control that rides along the divider chain
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

endpackage

// ----- hdl/bmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/bmf_div_cell.sv -----
// One cell of the restoring divider chain: settles one quotient bit.
module bmf_div_cell
    import bmf_pkg::*;
#(
    parameter int REM_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl_in,
    input  logic [REM_W-1:0] rem_in,
    input  logic [REM_W-1:0] dsh_in,
    input  logic [QUO_W-1:0] quo_in,
    output ctl_t             ctl_out,
    output logic [REM_W-1:0] rem_out,
    output logic [REM_W-1:0] dsh_out,
    output logic [QUO_W-1:0] quo_out
);

    logic ge;

    assign ge = (rem_in >= dsh_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_out <= '0;
        end
        else
        begin
            ctl_out <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_out <= ge ? (rem_in - dsh_in) : rem_in;
        dsh_out <= dsh_in >> 1;
        quo_out <= {quo_in[QUO_W-2:0], ge};
    end

endmodule

// ----- hdl/box_mean_filter_zero_pad.sv -----
// Top level of the zero-padded box mean filter.
//
//  channel  | dir | transfer when            | payload
//  ---------+-----+--------------------------+---------------------------------------
//  s_axis   | in  | tvalid & tready          | tdata[7:0] pixel_value, tuser operation
//  m_axis   | out | tvalid & tready          | tdata[7:0] filtered_pixel, tlast frame_last
//  apb      | in  | psel & penable & pwrite  | 0x0 frame_width, 0x4 frame_height,
//           |     |                          | 0x8 window_radius
//
// An item without a result passes through accept and decode only. An item with
// a result goes through accept, decode, one window pixel per cycle through the
// single read port of the line store, a flush state, then the 8-cell divider
// chain. The flush state repeats while an earlier result still waits in the
// output register. One item is worked on at a time; a finished result waits in
// the output register while the next item is taken. Reset clears control state
// only; the line store has no clearing pass.
module box_mean_filter_zero_pad
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic        s_axis_tuser,   // [0] operation
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] filtered_pixel
    output logic        m_axis_tlast,   // frame_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOTS    = 3 * MAX_RADIUS + 1;       // rows kept in the ring
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CW       = $clog2(MAX_WIDTH + 2);
    localparam int RWD      = $clog2(MAX_HEIGHT + 2);
    localparam int DEPTH    = SLOTS * MAX_WIDTH;
    localparam int AW       = $clog2(DEPTH);
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int WIN_W    = $clog2(SIDE_MAX);
    localparam int SUM_W    = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
    localparam int REM_W    = SUM_W + QUO_W;
    localparam int NY_W     = RWD + 1;
    localparam int NX_W     = CW + 1;
    localparam int PW       = RWD + CW;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DEC   = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_DIV   = 5'b10000
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [RAD_W-1:0] window_radius_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            window_radius_reg <= RST_WINDOW_RADIUS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_FRAME_WIDTH:   frame_width_reg   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= pwdata[CFG_W-1:0];
                REG_WINDOW_RADIUS: window_radius_reg <= pwdata[RAD_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_FRAME_WIDTH:   prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT:  prdata = 32'(frame_height_reg);
            REG_WINDOW_RADIUS: prdata = 32'(window_radius_reg);
            default:           prdata = '0;
        endcase
    end

    // effective geometry: zero width or height acts as one, large values saturate
    logic [CW-1:0]    w_eff;
    logic [RWD-1:0]   h_eff;
    logic [RAD_W-1:0] r_eff;
    logic [WIN_W-1:0] side_m1;
    logic [2:0]       side;
    logic [5:0]       side_sq;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = CW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(frame_width_reg);
        if (frame_height_reg == '0)
            h_eff = RWD'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = RWD'(MAX_HEIGHT);
        else
            h_eff = RWD'(frame_height_reg);
        r_eff   = (32'(window_radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                        : window_radius_reg;
        side_m1 = WIN_W'({r_eff, 1'b0});
        side    = {r_eff, 1'b1};
        side_sq = 6'(side) * 6'(side);
    end

    // ---------------- control registers ----------------
    state_t            state_reg, state_next;
    logic [CW-1:0]     in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RWD-1:0]    in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic [WIN_W-1:0]  wx_reg, wx_next, wy_reg, wy_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic              op_reg, op_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [NY_W-1:0]   ny_reg, ny_next;
    logic [NX_W-1:0]   nx_reg, nx_next, nx0_reg, nx0_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [PIX_W-1:0]  out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    // line store
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // divider chain
    ctl_t              ch_ctl [QUO_W+1];
    logic [REM_W-1:0]  ch_rem [QUO_W+1];
    logic [REM_W-1:0]  ch_dsh [QUO_W+1];
    logic [QUO_W-1:0]  ch_quo [QUO_W+1];
    logic [QUO_W-1:0]  ch_vld;
    ctl_t              launch_ctl;

    logic              accept;
    logic [PW-1:0]     pos, thr;
    logic              wr_ok, emit_dec, pos_ok, win_end;
    logic [SUM_W-1:0]  sum_final;
    logic [CW-1:0]     oc_inc;
    logic [RWD-1:0]    or_inc;
    logic [SLOT_W-1:0] os_inc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // position of this pixel in the frame against the lag of r rows and r pixels
    assign pos   = PW'(in_row_reg) * PW'(w_eff) + PW'(in_col_reg);
    assign thr   = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    assign wr_ok = (op_t'(op_reg) == OP_PIXEL) && (in_row_reg < h_eff);
    assign emit_dec = wr_ok ? (pos >= thr)
                            : ((in_row_reg >= h_eff) && (out_row_reg < h_eff));

    // window tap inside the frame? outside taps count as zero
    assign pos_ok  = !ny_reg[NY_W-1] && (ny_reg[RWD-1:0] < h_eff)
                  && !nx_reg[NX_W-1] && (nx_reg[CW-1:0] < w_eff);
    assign win_end = (wx_reg == side_m1) && (wy_reg == side_m1);

    assign sum_final = sum_reg + (pend_reg ? SUM_W'(ram_rdata) : '0);

    assign ram_we    = (state_reg == ST_DEC) && wr_ok;
    assign ram_waddr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);
    assign ram_re    = (state_reg == ST_SUM) && pos_ok;
    assign ram_raddr = AW'(wslot_reg) * AW'(MAX_WIDTH) + AW'(nx_reg[CW-1:0]);

    assign oc_inc = out_col_reg + 1'b1;
    assign or_inc = out_row_reg + 1'b1;
    assign os_inc = slot_inc(out_slot_reg);

    always_comb
    begin
        state_next     = state_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        op_next        = op_reg;
        pix_next       = pix_reg;
        ny_next        = ny_reg;
        nx_next        = nx_reg;
        nx0_next       = nx0_reg;
        wslot_next     = wslot_reg;
        sum_next       = sum_final;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        launch_ctl     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = s_axis_tuser;
                    pix_next = s_axis_tdata;
                    // positions left past a shrunk frame wrap or restart
                    if (in_col_next >= w_eff)
                    begin
                        in_col_next  = '0;
                        in_row_next  = in_row_next + 1'b1;
                        in_slot_next = slot_inc(in_slot_next);
                    end
                    if (in_row_next > h_eff)
                        in_row_next = h_eff;
                    if (out_col_next >= w_eff)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_next + 1'b1;
                        out_slot_next = slot_inc(out_slot_next);
                    end
                    if (out_row_next >= h_eff)
                    begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_slot_next  = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_slot_next = '0;
                    end
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (wr_ok)
                begin
                    if (in_col_reg + 1'b1 >= w_eff)
                    begin
                        in_col_next  = '0;
                        in_row_next  = in_row_reg + 1'b1;
                        in_slot_next = slot_inc(in_slot_reg);
                    end
                    else
                    begin
                        in_col_next = in_col_reg + 1'b1;
                    end
                end
                // window starts r rows up, r columns left
                sum_next   = '0;
                wx_next    = '0;
                wy_next    = '0;
                ny_next    = NY_W'(out_row_reg) - NY_W'(r_eff);
                nx_next    = NX_W'(out_col_reg) - NX_W'(r_eff);
                nx0_next   = NX_W'(out_col_reg) - NX_W'(r_eff);
                wslot_next = (out_slot_reg >= SLOT_W'(r_eff))
                           ? out_slot_reg - SLOT_W'(r_eff)
                           : out_slot_reg + SLOT_W'(SLOTS) - SLOT_W'(r_eff);
                state_next = emit_dec ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                pend_next = pos_ok;
                if (wx_reg == side_m1)
                begin
                    wx_next    = '0;
                    nx_next    = nx0_reg;
                    wy_next    = wy_reg + 1'b1;
                    ny_next    = ny_reg + 1'b1;
                    wslot_next = slot_inc(wslot_reg);
                end
                else
                begin
                    wx_next = wx_reg + 1'b1;
                    nx_next = nx_reg + 1'b1;
                end
                if (win_end)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                // launch once the output register is free; it stays free until
                // the quotient comes out of the chain
                if (!out_valid_reg)
                begin
                    launch_ctl.valid = 1'b1;
                    if (oc_inc >= w_eff)
                    begin
                        out_col_next  = '0;
                        out_row_next  = or_inc;
                        out_slot_next = os_inc;
                        if (or_inc >= h_eff)
                        begin
                            launch_ctl.last = 1'b1;
                            in_col_next     = '0;
                            in_row_next     = '0;
                            in_slot_next    = '0;
                            out_col_next    = '0;
                            out_row_next    = '0;
                            out_slot_next   = '0;
                        end
                    end
                    else
                    begin
                        out_col_next = oc_inc;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ch_ctl[QUO_W].valid)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ch_quo[QUO_W];
                    out_last_next  = ch_ctl[QUO_W].last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            wx_reg        <= wx_next;
            wy_reg        <= wy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pix_reg      <= pix_next;
        ny_reg       <= ny_next;
        nx_reg       <= nx_next;
        nx0_reg      <= nx0_next;
        wslot_reg    <= wslot_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // ring of the most recent rows
    bmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider chain: window sum over (2r+1)^2, one quotient bit per cell
    assign ch_ctl[0] = launch_ctl;
    assign ch_rem[0] = REM_W'(sum_final);
    assign ch_dsh[0] = REM_W'(side_sq) << (QUO_W - 1);
    assign ch_quo[0] = '0;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        bmf_div_cell #(
            .REM_W (REM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ch_ctl[k]),
            .rem_in  (ch_rem[k]),
            .dsh_in  (ch_dsh[k]),
            .quo_in  (ch_quo[k]),
            .ctl_out (ch_ctl[k+1]),
            .rem_out (ch_rem[k+1]),
            .dsh_out (ch_dsh[k+1]),
            .quo_out (ch_quo[k+1])
        );
        assign ch_vld[k] = ch_ctl[k+1].valid;
    end

`ifndef SYNTHESIS
    // never more than one quotient in flight
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(ch_vld))
        else $error("divider chain holds more than one item");

    // a quotient leaving the chain always finds the output register free
    assert property (@(posedge clk) disable iff (!rst_n)
        ch_ctl[QUO_W].valid |-> !out_valid_reg)
        else $error("quotient would overwrite a pending result");

    // a launch from the flush state enters the first cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && !out_valid_reg |=> ch_ctl[1].valid)
        else $error("launch lost on the way into the divider");
`endif

endmodule

// ----- bench/box_mean_filter_zero_pad_test.sv -----
// Self-checking bench for the zero-padded box mean filter.
module box_mean_filter_zero_pad_test;
    import bmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX  = 1024;
    localparam int ROW_RING  = 10;   // 3*MAX_RADIUS+1 rows kept by the predictor
    localparam int TAIL_CYC  = 200;  // settle time after the last result

    // item waiting to be driven
    typedef struct {
        op_t         op;
        logic [7:0]  pix;
    } pix_item_t;

    // expected filter output
    typedef struct {
        logic [7:0] mean;
        logic       last;
    } mean_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    box_mean_filter_zero_pad u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------
    // Predictor state: its own copy of registers, position counters and
    // a ring of recent rows.
    // ---------------------------------------------------------------
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [1:0]  cfg_radius;
    int unsigned col_in, row_in, col_out, row_out;
    logic [7:0]  row_ring [ROW_RING*LINE_MAX];

    pix_item_t   send_q[$];
    mean_res_t   mean_q[$];

    int          mismatches;
    int          n_results;
    int          n_lasts;
    int          n_sent;
    bit          in_fire;   // input transfer seen at the last rising edge

    function automatic int unsigned width_eff();
        int unsigned w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned height_eff();
        int unsigned h;
        h = cfg_height;
        if (h == 0) h = 1;
        if (h > 1024) h = 1024;
        return h;
    endfunction

    // truncated mean over the window at the current output position
    function automatic logic [7:0] box_mean(int unsigned w, int unsigned h, int unsigned r);
        int          ny;
        int          nx;
        int unsigned acc;
        int unsigned side;
        acc  = 0;
        side = 2*r + 1;
        for (int dy = -int'(r); dy <= int'(r); dy++)
        begin
            ny = int'(row_out) + dy;
            if (ny < 0 || ny >= int'(h)) continue;
            for (int dx = -int'(r); dx <= int'(r); dx++)
            begin
                nx = int'(col_out) + dx;
                if (nx < 0 || nx >= int'(w)) continue;
                acc += row_ring[(ny % ROW_RING)*LINE_MAX + nx];
            end
        end
        acc = acc / (side*side);
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    function automatic void push_mean(int unsigned w, int unsigned h, int unsigned r);
        mean_res_t res;
        res.mean = box_mean(w, h, r);
        res.last = 1'b0;
        col_out++;
        if (col_out >= w)
        begin
            col_out = 0;
            row_out++;
        end
        if (row_out >= h)
        begin
            res.last = 1'b1;
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        end
        mean_q.push_back(res);
    endfunction

    // advance the predictor by one accepted item
    function automatic void predict_item(op_t op, logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned pos;
        w = width_eff();
        h = height_eff();
        r = cfg_radius;
        if (col_in >= w) begin col_in = 0; row_in++; end
        if (row_in > h) row_in = h;
        if (col_out >= w) begin col_out = 0; row_out++; end
        if (row_out >= h)
        begin
            col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        end
        if (op == OP_PIXEL && row_in < h)
        begin
            pos = row_in*w + col_in;
            row_ring[(row_in % ROW_RING)*LINE_MAX + col_in] = pix;
            col_in++;
            if (col_in >= w)
            begin
                col_in = 0;
                row_in++;
            end
            if (pos >= r*w + r) push_mean(w, h, r);
        end
        else if (row_in >= h && row_out < h)
        begin
            push_mean(w, h, r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: one transfer per queued item, random gap after each.
    // ---------------------------------------------------------------
    int send_gap;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_fire)
            begin
                // hold current item until it transfers
            end
            else if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (send_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= send_q[0].op;
                s_axis_tdata  <= send_q[0].pix;
                send_q.pop_front();
                send_gap      <= (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall, redrawn per result
    int recv_gap;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input transfers, check on output transfers.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        mean_res_t exp_res;
        if (rst_n)
        begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_item(op_t'(s_axis_tuser), s_axis_tdata);
                n_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (m_axis_tlast) n_lasts++;
                recv_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
                if (mean_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result mean=%0d last=%0b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    exp_res = mean_q.pop_front();
                    if (exp_res.mean !== m_axis_tdata || exp_res.last !== m_axis_tlast)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mean exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, exp_res.mean, m_axis_tdata,
                                     exp_res.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Configuration and stimulus helpers
    // ---------------------------------------------------------------
    task automatic apb_write(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:   cfg_width  = value[10:0];
            REG_FRAME_HEIGHT:  cfg_height = value[10:0];
            REG_WINDOW_RADIUS: cfg_radius = value[1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every queued item to go out and every result to come back
    task automatic wait_idle();
        while (send_q.size() > 0 || s_axis_tvalid || mean_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_frame(int w, int h, int r);
        wait_idle();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_WINDOW_RADIUS, r);
    endtask

    task automatic queue_item(op_t op, logic [7:0] pix);
        pix_item_t it;
        it.op  = op;
        it.pix = pix;
        send_q.push_back(it);
    endtask

    // whole frame, then exactly the drains it needs; noise sprinkled in
    task automatic queue_frame(int w, int h, int r, int mode);
        int drains;
        for (int i = 0; i < w*h; i++)
        begin
            case (mode)
                0: queue_item(OP_PIXEL, 8'(255));
                1: queue_item(OP_PIXEL, 8'(0));
                default: queue_item(OP_PIXEL, 8'($urandom_range(0, 255)));
            endcase
            // early drain is ignored by the block; none after the last pixel
            if (mode == 3 && i < w*h - 1 && $urandom_range(0, 15) == 0)
                queue_item(OP_DRAIN, 8'($urandom));
        end
        drains = (r*w + r < w*h) ? r*w + r : w*h;
        for (int i = 0; i < drains; i++)
        begin
            // pixel past frame end acts as a drain
            if ($urandom_range(0, 5) == 0) queue_item(OP_PIXEL, 8'($urandom));
            else queue_item(OP_DRAIN, 8'($urandom));
        end
    endtask

    initial
    begin
        int w;
        int h;
        int r;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_gap      = 0;
        recv_gap      = 0;
        mismatches    = 0;
        n_results     = 0;
        n_lasts       = 0;
        n_sent        = 0;
        in_fire       = 1'b0;
        cfg_width     = RST_FRAME_WIDTH;
        cfg_height    = RST_FRAME_HEIGHT;
        cfg_radius    = RST_WINDOW_RADIUS;
        col_in = 0; row_in = 0; col_out = 0; row_out = 0;
        foreach (row_ring[i]) row_ring[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: all-white and all-black frames, radius extremes,
        // single pixel, width one, out-of-range register values
        set_frame(4, 3, 1);
        queue_frame(4, 3, 1, 0);
        set_frame(3, 3, 3);
        queue_frame(3, 3, 3, 1);
        set_frame(1, 1, 0);
        queue_frame(1, 1, 0, 2);
        // early drain on a fresh frame, then a frame with radius 0
        queue_item(OP_DRAIN, 8'hFF);
        queue_frame(1, 1, 0, 0);
        set_frame(0, 2047, 2);   // width zero acts as one, height saturates
        set_frame(1, 5, 2);
        queue_frame(1, 5, 2, 3);
        set_frame(5, 1, 3);
        queue_frame(5, 1, 3, 0);

        // one wide frame with the largest width
        set_frame(1024, 1, 0);
        queue_frame(1024, 1, 0, 2);
        // full stall: sender waits for every result before continuing
        wait_idle();

        // random frames, mostly small
        while (n_sent < 1500)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            r = $urandom_range(0, 3);
            set_frame(w, h, r);
            queue_frame(w, h, r, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : 3);
            if ($urandom_range(0, 1) == 0) queue_frame(w, h, r, 3);
            wait_idle();
        end

        wait_idle();
        repeat (TAIL_CYC) @(posedge clk);
        $display("Covered %0d input transfers, %0d results, %0d frame ends;",
                 n_sent, n_results, n_lasts);
        $display("radius 0..3, widths 1..1024, drains, early drains and stray pixels.");
        if (mismatches == 0 && mean_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results still expected", mismatches, mean_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard stop
    initial
    begin
        #20ms;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/bmf_pkg.sv
hdl/bmf_ram.sv
hdl/bmf_div_cell.sv
hdl/box_mean_filter_zero_pad.sv
bench/box_mean_filter_zero_pad_test.sv
